// ===== src/odo_pkg.sv =====
package odo_pkg;

  // CORDIC iteration count (8..24, arctangent table holds 24 entries)
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  // configuration register indexes
  localparam int          CFG_IDX_W   = 3;
  localparam logic [2:0]  REG_DPT     = 3'd0;
  localparam logic [2:0]  REG_START_X = 3'd1;
  localparam logic [2:0]  REG_START_Y = 3'd2;
  localparam logic [2:0]  REG_START_H = 3'd3;
  localparam logic [2:0]  REG_GOAL_X  = 3'd4;
  localparam logic [2:0]  REG_GOAL_Y  = 3'd5;

  localparam logic [15:0] DPT_RESET = 16'd2294;
  localparam logic [29:0] INV_GAIN  = 30'd652032874;
  localparam logic [16:0] HEAD_MOD  = 17'd36000;

  // arctangent of 2^-i in binary turns (2^32 = full circle)
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/odo_if.sv =====
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic signed [23:0] gyro_angle;
  modport source (output valid, left_count, right_count, gyro_angle, input ready);
  modport sink   (input valid, left_count, right_count, gyro_angle, output ready);
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic        [15:0] heading;
  logic        [31:0] goal_distance;
  logic signed [15:0] goal_bearing;
  modport source (output valid, x_pos, y_pos, heading, goal_distance, goal_bearing,
                  input ready);
  modport sink   (input valid, x_pos, y_pos, heading, goal_distance, goal_bearing,
                  output ready);
endinterface

interface odo_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [odo_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/odometry_position_tracker.sv =====
// Channel   Dir  Payload                                            Request
// in_i      in   left_count, right_count, gyro_angle                one sample
// out_o     out  x_pos, y_pos, heading, goal_distance, goal_bearing one result
// cfg_i     in   index (3b), data (32b)                             register write
//
// One sample runs from accept to result through a 10-step heading modulo,
// a 32-step bit-serial phase divide (move product formed bit-serially beside it),
// 16 rotation steps, a 32-step bit-serial axis multiply, 16 vectoring steps,
// a 30-step bit-serial gain multiply and five setup steps. No new sample is taken
// until the result is posted; the next one is taken from the cycle after that.
// rst_ni is asynchronous active low; positions reset to zero. A waiting result
// blocks only the final stage; the next sample is taken while it waits.
module odometry_position_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  odo_in_if.sink     in_i,
  odo_out_if.source  out_o,
  odo_cfg_if.sink    cfg_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HMOD  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RINIT = 4'd3;
  localparam logic [3:0] S_ROT   = 4'd4;
  localparam logic [3:0] S_MINIT = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_VINIT = 4'd8;
  localparam logic [3:0] S_VEC   = 4'd9;
  localparam logic [3:0] S_DMUL  = 4'd10;
  localparam logic [3:0] S_BEAR  = 4'd11;

  localparam logic [5:0] LAST_ITER = 6'(odo_pkg::CORDIC_N - 1);

  // control state
  logic [3:0]         state_q;
  logic [5:0]         cnt_q;
  logic               ov_q;
  logic [15:0]        dpt_q;
  logic [15:0]        sh_q;
  logic signed [31:0] gx_q, gy_q;
  logic signed [33:0] last_q;
  logic signed [31:0] px_q, py_q;

  // datapath
  logic [24:0]        hacc_q;
  logic [16:0]        rem_q;
  logic [31:0]        num_q, quo_q;
  logic signed [49:0] mcand_q, dq_q;
  logic [15:0]        mplr_q;
  logic               flip_q;
  logic signed [33:0] rx_q, ry_q;
  logic signed [32:0] rz_q;
  logic [49:0]        mag_q;
  logic [31:0]        tx_q, ty_q;
  logic [50:0]        accx_q, accy_q;
  logic               negx_q, negy_q, zero_q;
  logic signed [63:0] vx_q, vy_q;
  logic signed [33:0] vz_q;
  logic [29:0]        g_q;
  logic [64:0]        dacc_q;

  // output registers
  logic signed [31:0] ox_q, oy_q;
  logic [15:0]        oh_q;
  logic [31:0]        od_q;
  logic signed [15:0] ob_q;

  logic in_acc, out_free, last_it, ov_d;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign last_it  = cnt_q == LAST_ITER;
  // result valid: set when a result is posted, cleared when taken
  assign ov_d     = (state_q == S_BEAR && out_free) ? 1'b1 :
                    (out_o.ready ? 1'b0 : ov_q);

  assign in_i.ready = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = ov_q;
  assign out_o.x_pos = ox_q;
  assign out_o.y_pos = oy_q;
  assign out_o.heading = oh_q;
  assign out_o.goal_distance = od_q;
  assign out_o.goal_bearing = ob_q;

  // heading sum offset into a positive range, encoder delta
  logic signed [25:0] hsum;
  logic [25:0]        hpos;
  logic signed [32:0] csum;
  logic signed [33:0] cdiff;
  assign hsum  = 26'(in_i.gyro_angle) + $signed({10'b0, sh_q});
  assign hpos  = 26'(hsum + 26'sd9216000);
  assign csum  = 33'(in_i.left_count) + 33'(in_i.right_count);
  assign cdiff = 34'(csum) - last_q;

  // restoring modulo step
  logic [25:0] mod_sub;
  assign mod_sub = {1'b0, hacc_q} - ({9'b0, odo_pkg::HEAD_MOD} << cnt_q[3:0]);

  // restoring divide step
  logic [17:0] r2;
  logic [18:0] dsub;
  assign r2   = {rem_q, num_q[31]};
  assign dsub = {1'b0, r2} - {2'b0, odo_pkg::HEAD_MOD};

  // rotation init from the completed quotient
  logic [31:0] quo_n, ph2;
  logic        flip_n;
  assign quo_n  = {quo_q[30:0], !dsub[18]};
  assign flip_n = quo_n[31] ^ quo_n[30];
  assign ph2    = flip_n ? {~quo_n[31], quo_n[30:0]} : quo_n;

  // shared arctangent
  logic [29:0] atn;
  assign atn = odo_pkg::atan_turn(cnt_q[4:0]);

  // rotation step
  logic signed [33:0] rxs, rys;
  assign rxs = rx_q >>> cnt_q[4:0];
  assign rys = ry_q >>> cnt_q[4:0];

  // axis multiply init
  logic signed [33:0] cv, sv;
  logic [33:0]        cabs, sabs;
  assign cv   = flip_q ? -rx_q : rx_q;
  assign sv   = flip_q ? -ry_q : ry_q;
  assign cabs = cv[33] ? 34'(-cv) : 34'(cv);
  assign sabs = sv[33] ? 34'(-sv) : 34'(sv);

  // serial multiply steps
  logic [51:0] sumx, sumy;
  assign sumx = {1'b0, accx_q} + (tx_q[0] ? {2'b0, mag_q} : 52'd0);
  assign sumy = {1'b0, accy_q} + (ty_q[0] ? {2'b0, mag_q} : 52'd0);

  // rounding and saturating position update
  logic [51:0]        rndx, rndy;
  logic signed [46:0] stx, sty, nx, ny;
  logic signed [31:0] satx, saty;
  assign rndx = {1'b0, accx_q} + 52'd64;
  assign rndy = {1'b0, accy_q} + 52'd64;
  assign stx  = negx_q ? -$signed({2'b0, rndx[51:7]}) : $signed({2'b0, rndx[51:7]});
  assign sty  = negy_q ? -$signed({2'b0, rndy[51:7]}) : $signed({2'b0, rndy[51:7]});
  assign nx   = 47'(px_q) + stx;
  assign ny   = 47'(py_q) + sty;
  assign satx = (nx > 47'sd2147483647) ? 32'sh7FFFFFFF :
                (nx < -47'sd2147483648) ? 32'sh80000000 : nx[31:0];
  assign saty = (ny > 47'sd2147483647) ? 32'sh7FFFFFFF :
                (ny < -47'sd2147483648) ? 32'sh80000000 : ny[31:0];

  // goal vector
  logic signed [32:0] gdx, gdy;
  logic signed [63:0] vx0, vy0;
  assign gdx = 33'(gx_q) - 33'(px_q);
  assign gdy = 33'(gy_q) - 33'(py_q);
  assign vx0 = {{3{gdy[32]}}, gdy, 28'b0};
  assign vy0 = {{3{gdx[32]}}, gdx, 28'b0};

  // vectoring step
  logic signed [63:0] vxs, vys;
  logic               vpos;
  assign vxs  = vx_q >>> cnt_q[4:0];
  assign vys  = vy_q >>> cnt_q[4:0];
  assign vpos = !vy_q[63] && (vy_q != 64'sd0);

  // gain multiply step
  logic [65:0] dsum;
  assign dsum = {1'b0, dacc_q} + (g_q[0] ? {2'b0, vx_q} : 66'd0);

  // distance and bearing
  logic [65:0] drnd;
  logic [31:0] dist_sat;
  logic [33:0] az;
  logic [49:0] bprod;
  logic [50:0] brnd;
  logic [15:0] bmag;
  logic signed [15:0] bear;
  assign drnd     = {1'b0, dacc_q} + 66'd134217728;
  assign dist_sat = (|drnd[65:60]) ? 32'hFFFFFFFF : drnd[59:28];
  assign az       = vz_q[33] ? 34'(-vz_q) : 34'(vz_q);
  assign bprod    = 50'(az) * 50'(odo_pkg::HEAD_MOD);
  assign brnd     = {1'b0, bprod} + 51'h80000000;
  assign bmag     = (brnd[50:32] > 19'd18000) ? 16'd18000 : brnd[47:32];
  assign bear     = vz_q[33] ? -$signed(bmag) : $signed(bmag);

  // control: sequencer, configuration, tracked state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      dpt_q   <= odo_pkg::DPT_RESET;
      sh_q    <= '0;
      gx_q    <= '0;
      gy_q    <= '0;
      last_q  <= '0;
      px_q    <= '0;
      py_q    <= '0;
    end else begin
      ov_q <= ov_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          odo_pkg::REG_DPT:     dpt_q <= cfg_i.data[15:0];
          odo_pkg::REG_START_X: px_q  <= cfg_i.data;
          odo_pkg::REG_START_Y: py_q  <= cfg_i.data;
          odo_pkg::REG_START_H: sh_q  <= cfg_i.data[15:0];
          odo_pkg::REG_GOAL_X:  gx_q  <= cfg_i.data;
          odo_pkg::REG_GOAL_Y:  gy_q  <= cfg_i.data;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            last_q  <= 34'(csum);
            cnt_q   <= 6'd9;
            state_q <= S_HMOD;
          end
        end
        S_HMOD: begin
          if (cnt_q == 6'd0) state_q <= S_DIV;
          else cnt_q <= cnt_q - 6'd1;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) state_q <= S_RINIT;
        end
        S_RINIT: begin
          cnt_q   <= '0;
          state_q <= S_ROT;
        end
        S_ROT: begin
          cnt_q <= cnt_q + 6'd1;
          if (last_it) state_q <= S_MINIT;
        end
        S_MINIT: begin
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) state_q <= S_UPD;
        end
        S_UPD: begin
          px_q    <= satx;
          py_q    <= saty;
          state_q <= S_VINIT;
        end
        S_VINIT: begin
          cnt_q   <= '0;
          state_q <= S_VEC;
        end
        S_VEC: begin
          if (last_it) begin
            cnt_q   <= '0;
            state_q <= S_DMUL;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_DMUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd29) state_q <= S_BEAR;
        end
        S_BEAR: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        hacc_q  <= hsum[25] ? hpos[24:0] : hsum[24:0];
        mcand_q <= 50'(cdiff);
        dq_q    <= '0;
        mplr_q  <= dpt_q;
        num_q   <= 32'd18000;
      end
      S_HMOD: begin
        if (!mod_sub[25]) hacc_q <= mod_sub[24:0];
        rem_q <= '0;
        quo_q <= '0;
      end
      S_DIV: begin
        if (cnt_q == 6'd0) begin
          rem_q <= {1'b0, hacc_q[15:0]};
        end else begin
          rem_q <= !dsub[18] ? dsub[16:0] : r2[16:0];
          quo_q <= {quo_q[30:0], !dsub[18]};
          num_q <= {num_q[30:0], 1'b0};
        end
        if (cnt_q < 6'd16) begin
          if (mplr_q[0]) dq_q <= dq_q + mcand_q;
          mcand_q <= mcand_q <<< 1;
          mplr_q  <= {1'b0, mplr_q[15:1]};
        end
      end
      S_RINIT: begin
        // final quotient bit, then start vector from the folded phase
        rem_q  <= !dsub[18] ? dsub[16:0] : r2[16:0];
        quo_q  <= quo_n;
        flip_q <= flip_n;
        rx_q   <= 34'(odo_pkg::INV_GAIN);
        ry_q   <= '0;
        rz_q   <= 33'($signed(ph2));
      end
      S_ROT: begin
        if (!rz_q[32]) begin
          rx_q <= rx_q - rys;
          ry_q <= ry_q + rxs;
          rz_q <= rz_q - 33'(atn);
        end else begin
          rx_q <= rx_q + rys;
          ry_q <= ry_q - rxs;
          rz_q <= rz_q + 33'(atn);
        end
      end
      S_MINIT: begin
        mag_q  <= dq_q[49] ? 50'(-dq_q) : 50'(dq_q);
        negx_q <= dq_q[49] ^ sv[33];
        negy_q <= dq_q[49] ^ cv[33];
        tx_q   <= sabs[31:0];
        ty_q   <= cabs[31:0];
        accx_q <= '0;
        accy_q <= '0;
      end
      S_MUL: begin
        accx_q <= sumx[51:1];
        accy_q <= sumy[51:1];
        tx_q   <= {1'b0, tx_q[31:1]};
        ty_q   <= {1'b0, ty_q[31:1]};
      end
      S_UPD: ;
      S_VINIT: begin
        zero_q <= (gdx == 33'sd0) && (gdy == 33'sd0);
        g_q    <= odo_pkg::INV_GAIN;
        dacc_q <= '0;
        if (gdy[32]) begin
          vx_q <= -vx0;
          vy_q <= -vy0;
          vz_q <= gdx[32] ? -34'sd2147483648 : 34'sd2147483648;
        end else begin
          vx_q <= vx0;
          vy_q <= vy0;
          vz_q <= '0;
        end
      end
      S_VEC: begin
        if (vpos) begin
          vx_q <= vx_q + vys;
          vy_q <= vy_q - vxs;
          vz_q <= vz_q + 34'(atn);
        end else begin
          vx_q <= vx_q - vys;
          vy_q <= vy_q + vxs;
          vz_q <= vz_q - 34'(atn);
        end
      end
      S_DMUL: begin
        dacc_q <= dsum[65:1];
        g_q    <= {1'b0, g_q[29:1]};
      end
      S_BEAR: begin
        if (out_free) begin
          ox_q <= px_q;
          oy_q <= py_q;
          oh_q <= hacc_q[15:0];
          od_q <= zero_q ? 32'd0 : dist_sat;
          ob_q <= zero_q ? 16'sd0 : bear;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/odometry_position_tracker_test.sv =====
`timescale 1ns / 1ps

module odometry_position_tracker_test;

  // unused register indexes, writes there must change nothing
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int PLAN_ROWS = 24;
  localparam int PHASES = 8;
  localparam int PHASE_SAMPLES = 104;
  localparam int DRAIN_CYCLES = 200;

  // arctangent of 2^-i in binary turns
  localparam longint ATAN_TURNS [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };
  localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;

  typedef struct packed {
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic        [15:0] heading;
    logic        [31:0] goal_distance;
    logic signed [15:0] goal_bearing;
  } odo_fix_t;

  typedef struct {
    bit                 cfg_en;
    logic [2:0]         cfg_idx;
    logic [31:0]        cfg_data;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [23:0] gyro;
    bit                 typed;
    odo_fix_t           fix;
  } plan_row_t;

  logic clk;
  logic rst_n;
  bit   calm;
  int   mismatches;

  odo_in_if  in_ch ();
  odo_out_if out_ch ();
  odo_cfg_if cfg_ch ();

  odometry_position_tracker u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // tracker state mirrored by the testbench
  logic [15:0] trk_dpt;
  logic [15:0] trk_start_h;
  longint      trk_goal_x, trk_goal_y;
  longint      trk_last_sum, trk_pos_x, trk_pos_y;
  odo_fix_t    expected_fixes [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round(a*b / 2^sh)
  function automatic longint unsigned round_shr(input longint unsigned a,
                                                input longint unsigned b, input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    return p[63:0];
  endfunction

  function automatic void sin_cos(input logic [31:0] phase, output longint c,
                                  output longint s);
    longint      x, y, z, t;
    bit          flip;
    logic [31:0] ph;
    x = longint'(INV_GAIN_Q30);
    y = 0;
    ph = phase;
    flip = 1'b0;
    // fold the left half plane onto the right one
    if (ph >= 32'h4000_0000 && ph < 32'hC000_0000) begin
      ph = ph - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(ph));
    for (int i = 0; i < odo_pkg::CORDIC_N; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ATAN_TURNS[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += ATAN_TURNS[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint axis_step(input longint dq, input longint trig);
    bit              neg;
    longint unsigned r;
    neg = (dq < 0) != (trig < 0);
    r = round_shr(dq < 0 ? -dq : dq, trig < 0 ? -trig : trig, 39);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void goal_vector(input longint dx, input longint dy,
                                      output longint unsigned gdist, output longint bear);
    longint          x, y, z, t;
    longint unsigned m, az;
    gdist = 0;
    bear = 0;
    if (dx == 0 && dy == 0) return;
    x = dy * 268435456;
    y = dx * 268435456;
    z = 0;
    // goal behind: start from half a turn
    if (dy < 0) begin
      z = dx >= 0 ? 64'sd2147483648 : -64'sd2147483648;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < odo_pkg::CORDIC_N; i++) begin
      if (y > 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += ATAN_TURNS[i];
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ATAN_TURNS[i];
      end
    end
    m = round_shr(longint'(x), INV_GAIN_Q30, 58);
    gdist = m > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : m;
    az = z < 0 ? -z : z;
    bear = longint'((az * 36000 + 64'd2147483648) >> 32);
    if (bear > 18000) bear = 18000;
    if (z < 0) bear = -bear;
  endfunction

  function automatic odo_fix_t track_sample(input logic signed [31:0] left,
                                            input logic signed [31:0] right,
                                            input logic signed [23:0] gyro);
    longint          h, sum, dq, c, s, bear;
    longint unsigned ph64, gdist;
    odo_fix_t        fix;
    h = (longint'(gyro) + longint'(trk_start_h)) % 36000;
    if (h < 0) h += 36000;
    ph64 = ((longint'(h) << 32) + 18000) / 36000;
    sum = longint'(left) + longint'(right);
    dq = (sum - trk_last_sum) * longint'(trk_dpt);
    trk_last_sum = sum;
    sin_cos(ph64[31:0], c, s);
    trk_pos_x = clamp32(trk_pos_x + axis_step(dq, s));
    trk_pos_y = clamp32(trk_pos_y + axis_step(dq, c));
    goal_vector(trk_goal_x - trk_pos_x, trk_goal_y - trk_pos_y, gdist, bear);
    fix.x_pos = trk_pos_x[31:0];
    fix.y_pos = trk_pos_y[31:0];
    fix.heading = h[15:0];
    fix.goal_distance = gdist[31:0];
    fix.goal_bearing = bear[15:0];
    return fix;
  endfunction

  function automatic void track_cfg(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      odo_pkg::REG_DPT:     trk_dpt = data[15:0];
      odo_pkg::REG_START_X: trk_pos_x = longint'($signed(data));
      odo_pkg::REG_START_Y: trk_pos_y = longint'($signed(data));
      odo_pkg::REG_START_H: trk_start_h = data[15:0];
      odo_pkg::REG_GOAL_X:  trk_goal_x = longint'($signed(data));
      odo_pkg::REG_GOAL_Y:  trk_goal_y = longint'($signed(data));
      default: ;
    endcase
  endfunction

  // one sample request; valid stays high on return
  task automatic send_sample(input logic signed [31:0] left, input logic signed [31:0] right,
                             input logic signed [23:0] gyro, input bit typed,
                             input odo_fix_t typed_fix);
    int       gap;
    odo_fix_t fix;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.left_count <= left;
    in_ch.right_count <= right;
    in_ch.gyro_angle <= gyro;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    fix = track_sample(left, right, gyro);
    expected_fixes.push_back(typed ? typed_fix : fix);
  endtask

  // register write request; valid stays high on return
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    track_cfg(idx, data);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_reg_value(input logic [2:0] idx);
    case (idx)
      odo_pkg::REG_DPT: begin
        case ($urandom_range(0, 5))
          0: return 32'd0;
          1: return 32'hFFFF;
          2: return $urandom();
          default: return $urandom_range(1, 8000);
        endcase
      end
      odo_pkg::REG_START_H:
        return $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 35999);
      odo_pkg::REG_START_X, odo_pkg::REG_START_Y, odo_pkg::REG_GOAL_X,
      odo_pkg::REG_GOAL_Y: return rand_coord();
      default: return $urandom();
    endcase
  endfunction

  // result check
  always @(posedge clk) begin
    odo_fix_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.x_pos, out_ch.y_pos, out_ch.heading, out_ch.goal_distance,
              out_ch.goal_bearing};
      if (expected_fixes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = expected_fixes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: x %0d/%0d y %0d/%0d hdg %0d/%0d dist %0d/%0d brg %0d/%0d",
                     want.x_pos, got.x_pos, want.y_pos, got.y_pos,
                     want.heading, got.heading, want.goal_distance, got.goal_distance,
                     want.goal_bearing, got.goal_bearing);
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    plan_row_t      plan [0:PLAN_ROWS-1];
    logic signed [31:0] cur_l, cur_r;
    logic signed [23:0] cur_g;
    logic [2:0]     idx;
    int             nwr;
    plan = '{
      '{0, odo_pkg::REG_DPT, 0, 0, 0, 0, 1, '{32'sd0, 32'sd0, 16'd0, 32'd0, 16'sd0}},
      '{0, odo_pkg::REG_DPT, 0, 0, 0, -1, 1, '{32'sd0, 32'sd0, 16'd35999, 32'd0, 16'sd0}},
      '{0, odo_pkg::REG_DPT, 0, 0, 0, 36000, 1, '{32'sd0, 32'sd0, 16'd0, 32'd0, 16'sd0}},
      '{0, odo_pkg::REG_DPT, 0, 0, 0, 24'sh7FFFFF, 1,
        '{32'sd0, 32'sd0, 16'd607, 32'd0, 16'sd0}},
      '{0, odo_pkg::REG_DPT, 0, 0, 0, 24'sh800000, 1,
        '{32'sd0, 32'sd0, 16'd35392, 32'd0, 16'sd0}},
      '{0, odo_pkg::REG_DPT, 0, 100, 100, 0, 0, '0},
      '{1, odo_pkg::REG_START_H, 9000, 300, 100, 0, 0, '0},
      // heading offset above one turn still wraps
      '{1, odo_pkg::REG_START_H, 65535, 300, 100, -100, 0, '0},
      // full-scale moves drive both axes into saturation
      '{1, odo_pkg::REG_DPT, 32'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 18000, 0, '0},
      '{0, odo_pkg::REG_DPT, 0, 32'sh80000000, 32'sh80000000, 27000, 0, '0},
      '{1, odo_pkg::REG_DPT, 0, 5, 5, 0, 0, '0},
      '{1, odo_pkg::REG_START_X, 1000, 5, 5, 0, 0, '0},
      '{1, odo_pkg::REG_START_Y, -2000, 5, 5, 0, 0, '0},
      '{1, odo_pkg::REG_GOAL_X, 1000, 5, 5, 0, 0, '0},
      // sitting on the goal
      '{1, odo_pkg::REG_GOAL_Y, -2000, 5, 5, 0, 1,
        '{32'sd1000, -32'sd2000, 16'd29535, 32'd0, 16'sd0}},
      // goal straight behind
      '{1, odo_pkg::REG_GOAL_Y, -90000, 5, 5, 0, 0, '0},
      '{1, REG_SPARE_6, 32'hFFFF_FFFF, 5, 5, 0, 0, '0},
      '{1, REG_SPARE_7, 32'h1234_5678, 5, 5, 0, 0, '0},
      '{1, odo_pkg::REG_START_H, 0, 5, 5, 0, 0, '0},
      '{1, odo_pkg::REG_GOAL_X, 32'h7FFF_FFFF, 5, 5, 0, 0, '0},
      '{1, odo_pkg::REG_GOAL_Y, 32'h8000_0000, 5, 5, 0, 0, '0},
      '{1, odo_pkg::REG_START_X, 32'h8000_0000, 5, 5, 0, 0, '0},
      // goal distance past 32 bits
      '{1, odo_pkg::REG_START_Y, 32'h7FFF_FFFF, 5, 5, 0, 0, '0},
      '{1, odo_pkg::REG_DPT, 2294, 12, 3, 4500, 0, '0}
    };

    trk_dpt = odo_pkg::DPT_RESET;
    trk_start_h = '0;
    trk_goal_x = 0;
    trk_goal_y = 0;
    trk_last_sum = 0;
    trk_pos_x = 0;
    trk_pos_y = 0;
    mismatches = 0;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.left_count = '0;
    in_ch.right_count = '0;
    in_ch.gyro_angle = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, registers only written with nothing in flight
    foreach (plan[i]) begin
      if (plan[i].cfg_en) begin
        drain();
        write_reg(plan[i].cfg_idx, plan[i].cfg_data);
        cfg_ch.valid <= 1'b0;
      end
      send_sample(plan[i].left, plan[i].right, plan[i].gyro, plan[i].typed, plan[i].fix);
    end

    // random phases: mostly smooth wheel motion, some jumps and noise
    cur_l = 32'sd12;
    cur_r = 32'sd3;
    cur_g = 24'sd4500;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      nwr = $urandom_range(1, 4);
      for (int w = 0; w < nwr; w++) begin
        idx = 3'($urandom_range(0, 7));
        write_reg(idx, rand_reg_value(idx));
      end
      cfg_ch.valid <= 1'b0;
      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        case ($urandom_range(0, 9))
          0: begin
            cur_l = $urandom();
            cur_r = $urandom();
            cur_g = 24'($urandom());
          end
          1: begin
            cur_l = cur_l + $urandom_range(0, 32'hFFFFF) - 32'h80000;
            cur_r = cur_r + $urandom_range(0, 32'hFFFFF) - 32'h80000;
            cur_g = 24'(cur_g + $urandom_range(0, 80000) - 40000);
          end
          default: begin
            cur_l = cur_l + $urandom_range(0, 4000) - 2000;
            cur_r = cur_r + $urandom_range(0, 4000) - 2000;
            cur_g = 24'(cur_g + $urandom_range(0, 2000) - 1000);
          end
        endcase
        send_sample(cur_l, cur_r, cur_g, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_fixes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
